/* design/csh_pkg.sv */
// ----------------------------------------------------------------------------
// csh_pkg
// Shared constants for the color structure histogram block: field widths,
// default sizes, reset size, step limits, register indexes and operation codes.
// ----------------------------------------------------------------------------
package csh_pkg;

    localparam int CFG_W        = 11;
    localparam int PIXEL_W      = 8;
    localparam int SEL_W        = 8;
    localparam int COUNT_W      = 21;
    localparam int P_W          = 3;
    localparam int P_LIMIT      = 7;
    localparam int P_AREA_BASE  = 17;
    localparam int RESET_DIM    = 256;

    localparam int DEF_NUM_BINS       = 256;
    localparam int DEF_MAX_WIDTH      = 1024;
    localparam int DEF_MAX_HEIGHT     = 1024;
    localparam int DEF_WINDOW_SAMPLES = 8;

    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

endpackage

/* design/color_structure_histogram.sv */
// ----------------------------------------------------------------------------
// color_structure_histogram
// Stores a color-index image one pixel per word and, after the last pixel,
// builds the color structure histogram with a sliding sample window.
// ----------------------------------------------------------------------------
// Load word: written into the pixel memory when accepted. Read word: held in r_rd_pend
//   and r_sel, then the result is registered into r_o_valid and r_count.
// After the last pixel the block stalls for the histogram pass; the pass is
//   bound by one shared read-modify-write sequencer on the window memory.
// Reset (synchronous): histogram cleared by the pass, load position zero,
//   registers to 256 x 256; pixel memory holds no reset value.
module color_structure_histogram #(
    parameter int NUM_BINS       = csh_pkg::DEF_NUM_BINS,
    parameter int MAX_WIDTH      = csh_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = csh_pkg::DEF_MAX_HEIGHT,
    parameter int WINDOW_SAMPLES = csh_pkg::DEF_WINDOW_SAMPLES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [csh_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_op,
    input  logic [csh_pkg::PIXEL_W-1:0] i_pixel_color,
    input  logic [csh_pkg::SEL_W-1:0]   i_bin_select,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [csh_pkg::SEL_W-1:0]   o_bin_number,
    output logic [csh_pkg::COUNT_W-1:0] o_bin_count
);

    localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW   = $clog2(MAXD + 1);
    localparam int XW   = DW + 1;
    localparam int EW   = (DW > csh_pkg::CFG_W) ? DW : csh_pkg::CFG_W;
    localparam int AW   = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int ARW  = 2 * DW;
    localparam int TW   = (ARW > AW + 1) ? ARW : AW + 1;
    localparam int BW   = $clog2(NUM_BINS);
    localparam int JW   = $clog2(WINDOW_SAMPLES);
    localparam int CW   = $clog2(WINDOW_SAMPLES * WINDOW_SAMPLES + 1);
    localparam int SPW  = $clog2(WINDOW_SAMPLES) + 8;
    localparam int MW   = (DW > SPW) ? DW : SPW;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLR_SH,
        S_COL_CLR,
        S_FILL,
        S_TALLY,
        S_SLIDE
    } t_state;

    logic [csh_pkg::PIXEL_W-1:0] r_img [STORE_DEPTH];
    logic [CW-1:0]               r_wh  [NUM_BINS];
    logic [csh_pkg::COUNT_W-1:0] r_sh  [NUM_BINS];

    t_state                      r_state;
    logic [1:0]                  r_ph;
    logic [BW-1:0]               r_b;
    logic [JW-1:0]               r_j;
    logic [JW-1:0]               r_r;
    logic                        r_add;
    logic [XW-1:0]               r_col;
    logic [XW-1:0]               r_row;
    logic [XW-1:0]               r_cj;
    logic [AW:0]                 r_top;
    logic [AW:0]                 r_rowa;
    logic [AW:0]                 r_rstep;
    logic [csh_pkg::P_W-1:0]     r_p;
    logic [DW-1:0]               r_w;
    logic [DW-1:0]               r_h;
    logic [DW-1:0]               r_modw;
    logic [DW-1:0]               r_modh;
    logic [BW-1:0]               r_cidx;
    logic [AW-1:0]               r_pos;
    logic                        r_rd_pend;
    logic                        r_o_valid;
    logic [csh_pkg::SEL_W-1:0]   r_sel;
    logic [csh_pkg::COUNT_W-1:0] r_count;
    logic [csh_pkg::CFG_W-1:0]   r_cfg_w;
    logic [csh_pkg::CFG_W-1:0]   r_cfg_h;

    logic [csh_pkg::PIXEL_W-1:0] r_img_q;
    logic [CW-1:0]               r_wh_q;
    logic [csh_pkg::COUNT_W-1:0] r_sh_q;

    logic [EW-1:0]               s_wx;
    logic [EW-1:0]               s_hx;
    logic [DW-1:0]               s_eff_w;
    logic [DW-1:0]               s_eff_h;
    logic [ARW-1:0]              s_eff_area;
    logic [ARW-1:0]              s_area;
    logic                        s_last;
    logic [csh_pkg::P_W-1:0]     s_p;
    logic [SPW-1:0]              s_span;
    logic                        s_small;
    logic [XW-1:0]               s_sub;
    logic [XW-1:0]               s_col_n;
    logic [AW:0]                 s_base;
    logic [AW:0]                 s_pix_addr;
    logic [BW-1:0]               s_color;
    logic                        s_busy;
    logic                        s_acc;
    logic                        s_load;
    logic                        s_dec;
    logic                        s_img_we;
    logic                        s_wh_we;
    logic [BW-1:0]               s_wh_ra;
    logic [BW-1:0]               s_wh_wa;
    logic [CW-1:0]               s_wh_wd;
    logic                        s_sh_we;
    logic [BW-1:0]               s_sh_ra;
    logic [csh_pkg::COUNT_W-1:0] s_sh_wd;

    always_comb begin
        s_wx = EW'(r_cfg_w);
        s_hx = EW'(r_cfg_h);
        if (s_wx == '0) begin
            s_eff_w = DW'(1);
        end else if (s_wx > EW'(MAX_WIDTH)) begin
            s_eff_w = DW'(MAX_WIDTH);
        end else begin
            s_eff_w = DW'(s_wx);
        end
        if (s_hx == '0) begin
            s_eff_h = DW'(1);
        end else if (s_hx > EW'(MAX_HEIGHT)) begin
            s_eff_h = DW'(MAX_HEIGHT);
        end else begin
            s_eff_h = DW'(s_hx);
        end
    end

    assign s_eff_area = ARW'(s_eff_w) * ARW'(s_eff_h);
    assign s_last     = (TW'(r_pos) + TW'(1)) >= TW'(s_eff_area);
    assign s_area     = ARW'(r_w) * ARW'(r_h);

    always_comb begin
        s_p = '0;
        for (int k = 0; k < csh_pkg::P_LIMIT; k++) begin
            if (64'(s_area) >= (64'(1) << (2 * k + csh_pkg::P_AREA_BASE))) begin
                s_p = csh_pkg::P_W'(k + 1);
            end
        end
    end

    assign s_span  = SPW'(WINDOW_SAMPLES) << r_p;
    assign s_small = (MW'(r_w) < MW'(s_span)) || (MW'(r_h) < MW'(s_span));
    assign s_sub   = XW'(1) << r_p;
    assign s_col_n = r_col + s_sub;

    assign s_busy = (r_state != S_IDLE);
    assign o_stall = s_busy || r_rd_pend || ((i_op == csh_pkg::OP_READ) && r_o_valid);
    assign s_acc  = i_valid && !o_stall;
    assign s_load = s_acc && (i_op == csh_pkg::OP_LOAD);

    assign s_base     = ((r_state == S_SLIDE) && !r_add) ? r_top : r_rowa;
    assign s_pix_addr = s_base + (AW + 1)'(r_cj);
    assign s_color    = ((csh_pkg::PIXEL_W + 1)'(r_img_q) >= (csh_pkg::PIXEL_W + 1)'(NUM_BINS))
                        ? BW'(NUM_BINS - 1) : BW'(r_img_q);
    assign s_dec      = (r_state == S_SLIDE) && !r_add;
    assign s_img_we   = s_load;

    always_comb begin
        s_wh_ra = (r_state == S_TALLY) ? r_b : s_color;
        s_wh_we = (r_state == S_COL_CLR) ||
                  (((r_state == S_FILL) || (r_state == S_SLIDE)) && (r_ph == 2'd2));
        s_wh_wa = (r_state == S_COL_CLR) ? r_b : r_cidx;
        if (r_state == S_COL_CLR) begin
            s_wh_wd = '0;
        end else if (s_dec) begin
            s_wh_wd = (r_wh_q != '0) ? r_wh_q - CW'(1) : r_wh_q;
        end else begin
            s_wh_wd = r_wh_q + CW'(1);
        end
        s_sh_ra = s_busy ? r_b : BW'(i_bin_select);
        s_sh_we = (r_state == S_CLR_SH) ||
                  ((r_state == S_TALLY) && (r_ph == 2'd1) && (r_wh_q != '0) &&
                   (r_sh_q != csh_pkg::COUNT_MAX));
        s_sh_wd = (r_state == S_CLR_SH) ? '0 : r_sh_q + csh_pkg::COUNT_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (s_img_we) begin
            r_img[r_pos] <= i_pixel_color;
        end
        r_img_q <= r_img[s_pix_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (s_wh_we) begin
            r_wh[s_wh_wa] <= s_wh_wd;
        end
        r_wh_q <= r_wh[s_wh_ra];
    end

    always_ff @(posedge i_clk) begin
        if (s_sh_we) begin
            r_sh[r_b] <= s_sh_wd;
        end
        r_sh_q <= r_sh[s_sh_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= csh_pkg::CFG_W'(csh_pkg::RESET_DIM);
            r_cfg_h <= csh_pkg::CFG_W'(csh_pkg::RESET_DIM);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                csh_pkg::REG_IMAGE_WIDTH:  r_cfg_w <= i_cfg_data;
                csh_pkg::REG_IMAGE_HEIGHT: r_cfg_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR_SH;
            r_ph      <= '0;
            r_b       <= '0;
            r_pos     <= '0;
            r_rd_pend <= 1'b0;
            r_o_valid <= 1'b0;
            r_w       <= '0;
            r_h       <= '0;
            r_p       <= '0;
            r_j       <= '0;
            r_r       <= '0;
            r_add     <= 1'b0;
        end else begin
            r_rd_pend <= s_acc && (i_op == csh_pkg::OP_READ);
            if (s_acc && (i_op == csh_pkg::OP_READ)) begin
                r_sel <= i_bin_select;
            end
            if (r_rd_pend) begin
                r_o_valid <= 1'b1;
                r_count   <= ((csh_pkg::SEL_W + 1)'(r_sel) < (csh_pkg::SEL_W + 1)'(NUM_BINS))
                             ? r_sh_q : '0;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (s_load) begin
                        if (s_last) begin
                            r_w     <= s_eff_w;
                            r_h     <= s_eff_h;
                            r_b     <= '0;
                            r_pos   <= '0;
                            r_state <= S_CLR_SH;
                        end else begin
                            r_pos <= r_pos + AW'(1);
                        end
                    end
                end
                S_CLR_SH: begin
                    if (r_b == '0) begin
                        r_p <= s_p;
                    end
                    if (r_b == BW'(NUM_BINS - 1)) begin
                        r_b <= '0;
                        if (s_small) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_modw  <= r_w - DW'(s_span) + DW'(1);
                            r_modh  <= r_h - DW'(s_span) + DW'(1);
                            r_rstep <= (AW + 1)'(r_w) << r_p;
                            r_col   <= '0;
                            r_state <= S_COL_CLR;
                        end
                    end else begin
                        r_b <= r_b + BW'(1);
                    end
                end
                S_COL_CLR: begin
                    if (r_b == BW'(NUM_BINS - 1)) begin
                        r_b     <= '0;
                        r_ph    <= '0;
                        r_j     <= '0;
                        r_r     <= '0;
                        r_cj    <= r_col;
                        r_top   <= '0;
                        r_rowa  <= '0;
                        r_row   <= s_sub;
                        r_state <= S_FILL;
                    end else begin
                        r_b <= r_b + BW'(1);
                    end
                end
                S_FILL: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_cidx <= s_color;
                            r_ph   <= 2'd2;
                        end
                        default: begin
                            r_ph <= 2'd0;
                            if (r_j == JW'(WINDOW_SAMPLES - 1)) begin
                                r_j    <= '0;
                                r_cj   <= r_col;
                                r_rowa <= r_rowa + r_rstep;
                                if (r_r == JW'(WINDOW_SAMPLES - 1)) begin
                                    r_b     <= '0;
                                    r_state <= S_TALLY;
                                end else begin
                                    r_r <= r_r + JW'(1);
                                end
                            end else begin
                                r_j  <= r_j + JW'(1);
                                r_cj <= r_cj + s_sub;
                            end
                        end
                    endcase
                end
                S_TALLY: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph <= 2'd0;
                        if (r_b == BW'(NUM_BINS - 1)) begin
                            r_b <= '0;
                            if (r_row < XW'(r_modh)) begin
                                r_add   <= 1'b0;
                                r_j     <= '0;
                                r_cj    <= r_col;
                                r_state <= S_SLIDE;
                            end else if (s_col_n < XW'(r_modw)) begin
                                r_col   <= s_col_n;
                                r_state <= S_COL_CLR;
                            end else begin
                                r_state <= S_IDLE;
                            end
                        end else begin
                            r_b <= r_b + BW'(1);
                        end
                    end
                end
                S_SLIDE: begin
                    case (r_ph)
                        2'd0: r_ph <= 2'd1;
                        2'd1: begin
                            r_cidx <= s_color;
                            r_ph   <= 2'd2;
                        end
                        default: begin
                            r_ph <= 2'd0;
                            if (!r_add) begin
                                r_add <= 1'b1;
                            end else begin
                                r_add <= 1'b0;
                                if (r_j == JW'(WINDOW_SAMPLES - 1)) begin
                                    r_j     <= '0;
                                    r_cj    <= r_col;
                                    r_top   <= r_top + r_rstep;
                                    r_rowa  <= r_rowa + r_rstep;
                                    r_row   <= r_row + s_sub;
                                    r_b     <= '0;
                                    r_state <= S_TALLY;
                                end else begin
                                    r_j  <= r_j + JW'(1);
                                    r_cj <= r_cj + s_sub;
                                end
                            end
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_o_valid;
    assign o_bin_number = r_sel;
    assign o_bin_count  = r_count;

    a_pend_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> !r_o_valid)
        else $error("read result pending while output word occupied");

    a_start_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && s_load && s_last) |=> (r_state == S_CLR_SH && r_pos == '0))
        else $error("last pixel did not start histogram pass");

    a_addr_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL || r_state == S_SLIDE) |-> (TW'(s_pix_addr) < TW'(s_area)))
        else $error("pixel address outside loaded image");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_acc)
        else $error("word accepted during histogram pass");

endmodule

/* verif/csh_checker.sv */
// ----------------------------------------------------------------------------
// csh_checker
// Watches the configuration port and both word channels of the color
// structure histogram block. It keeps its own image store and histogram,
// predicts every read word and compares each output word with the oldest
// prediction.
// ----------------------------------------------------------------------------
module csh_checker
    import csh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    input  logic               i_in_stall,
    input  logic               i_op,
    input  logic [PIXEL_W-1:0] i_pixel_color,
    input  logic [SEL_W-1:0]   i_bin_select,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [SEL_W-1:0]   i_bin_number,
    input  logic [COUNT_W-1:0] i_bin_count,
    output int                 o_errors,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NB    = DEF_NUM_BINS;
    localparam int MAXW  = DEF_MAX_WIDTH;
    localparam int MAXH  = DEF_MAX_HEIGHT;
    localparam int WS    = DEF_WINDOW_SAMPLES;

    typedef struct packed {
        logic [SEL_W-1:0]   number;
        logic [COUNT_W-1:0] count;
    } bin_word_t;

    bit [PIXEL_W-1:0] pixels [0:MAXW*MAXH-1];
    int unsigned      struct_hist [NB];
    int unsigned      win_hist [NB];
    int unsigned      load_pos;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    bin_word_t        expected_bins [$];

    assign o_pending = expected_bins.size();

    function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    function automatic void add_window();
        for (int b = 0; b < NB; b++)
            if (win_hist[b] != 0 && struct_hist[b] < COUNT_MAX) struct_hist[b]++;
    endfunction

    function automatic void build_histogram();
        int unsigned w, h, p, sub, span, lim_w, lim_h, del, add, cd;
        longint unsigned area;
        w = clamp_dim(width_reg, MAXW);
        h = clamp_dim(height_reg, MAXH);
        area = longint'(w) * h;
        p = 0;
        foreach (struct_hist[b]) struct_hist[b] = 0;
        while (p < P_LIMIT && area >= (64'd1 << (2 * p + P_AREA_BASE))) p++;
        sub = 1 << p;
        span = WS * sub;
        if (w < span || h < span) return;
        lim_w = w - span + 1;
        lim_h = h - span + 1;
        for (int unsigned col = 0; col < lim_w; col += sub) begin
            foreach (win_hist[b]) win_hist[b] = 0;
            for (int unsigned row = 0; row < span; row += sub)
                for (int j = 0; j < WS; j++)
                    win_hist[pixels[row * w + col + j * sub]]++;
            add_window();
            for (int unsigned row = sub; row < lim_h; row += sub) begin
                del = (row - sub) * w + col;
                add = (row + span - sub) * w + col;
                for (int j = 0; j < WS; j++) begin
                    cd = pixels[del + j * sub];
                    if (win_hist[cd] != 0) win_hist[cd]--;
                    win_hist[pixels[add + j * sub]]++;
                end
                add_window();
            end
        end
    endfunction

    task automatic report(string what, int unsigned got, int unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;

    always @(posedge i_clk) begin
        bin_word_t want;
        if (!i_rst_n) begin
            foreach (struct_hist[b]) struct_hist[b] = 0;
            load_pos   = 0;
            width_reg  = RESET_DIM;
            height_reg = RESET_DIM;
            expected_bins.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_IMAGE_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_bins.size() == 0) begin
                    report("unexpected word, bin_number", i_bin_number, 0);
                end else begin
                    want = expected_bins.pop_front();
                    if (i_bin_number !== want.number)
                        report("bin_number", i_bin_number, want.number);
                    if (i_bin_count !== want.count)
                        report("bin_count", i_bin_count, want.count);
                end
            end
            if (i_valid && !i_in_stall) begin
                if (i_op == OP_LOAD) begin
                    pixels[load_pos] = i_pixel_color;
                    load_pos++;
                    if (load_pos >= clamp_dim(width_reg, MAXW) * clamp_dim(height_reg, MAXH)) begin
                        build_histogram();
                        load_pos = 0;
                    end
                end else begin
                    want.number = i_bin_select;
                    want.count  = (i_bin_select < NB) ? struct_hist[i_bin_select] : 0;
                    expected_bins.push_back(want);
                end
            end
        end
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Stimulus for the color structure histogram block: loads images of many
// sizes, including the register extremes, reads bins around each image end,
// and randomly idles both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import csh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic               cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [PIXEL_W-1:0] pixel_color;
    logic [SEL_W-1:0]   bin_select;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [SEL_W-1:0]   bin_number;
    logic [COUNT_W-1:0] bin_count;
    int                 errors;
    int                 pending;
    bit                 idle_on;
    int                 sent;
    logic [PIXEL_W-1:0] palette [4];

    color_structure_histogram i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_op(op), .i_pixel_color(pixel_color), .i_bin_select(bin_select),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_bin_number(bin_number), .o_bin_count(bin_count)
    );

    csh_checker i_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_in_stall(in_stall),
        .i_op(op), .i_pixel_color(pixel_color), .i_bin_select(bin_select),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_bin_number(bin_number), .i_bin_count(bin_count),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #(12ns * 30_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk) begin
        if (idle_on && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        out_stall <= 1'b0;
    end

    task automatic send_word(logic kind, logic [PIXEL_W-1:0] color, logic [SEL_W-1:0] sel);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= kind;
        pixel_color <= color;
        bin_select  <= sel;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic write_reg(logic idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_image(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, bit use_palette);
        int unsigned ew, eh;
        logic [PIXEL_W-1:0] color;
        ew = (w == 0) ? 1 : ((w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w);
        eh = (h == 0) ? 1 : ((h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        foreach (palette[k]) palette[k] = $urandom_range(0, 255);
        for (int unsigned n = 0; n < ew * eh; n++) begin
            if (ew * eh < 400 && $urandom_range(0, 4) == 0)
                send_word(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255));
            color = use_palette ? palette[$urandom_range(0, 3)] : $urandom_range(0, 255);
            send_word(OP_LOAD, color, $urandom_range(0, 255));
        end
        for (int k = 0; k < 4; k++)
            send_word(OP_READ, $urandom_range(0, 255), palette[k]);
        send_word(OP_READ, 8'h00, 8'h00);
        send_word(OP_READ, 8'hFF, 8'hFF);
        drain();
    endtask

    initial begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_IMAGE_WIDTH;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = OP_LOAD;
        pixel_color = '0;
        bin_select  = '0;
        idle_on     = 1'b1;
        sent        = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(OP_READ, 8'h00, 8'h00);
        send_word(OP_READ, 8'hFF, 8'hFF);
        drain();
        run_image(11'd8, 11'd8, 1'b0);
        run_image(11'd8, 11'd8, 1'b1);
        run_image(11'd1, 11'd1, 1'b0);
        run_image(11'd0, 11'd7, 1'b0);
        run_image(11'd2047, 11'd1, 1'b1);
        run_image(11'd9, 11'd8, 1'b1);

        while (sent < 2000) begin
            if (sent > 1700) idle_on = 1'b0;
            if ($urandom_range(0, 4) == 0)
                run_image($urandom_range(1, 20), $urandom_range(1, 7), $urandom_range(0, 1));
            else
                run_image($urandom_range(8, 14), $urandom_range(8, 14), $urandom_range(0, 1));
        end

        idle_on = 1'b0;
        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
design/csh_pkg.sv
design/color_structure_histogram.sv
verif/csh_checker.sv
verif/tb.sv
